// File: sv/gsfr_pkg.sv
// Package for the grasp slip force regulator.
// Holds register indexes, reset values, widths, slip codes and sequencer states.
// No dependencies.
package gsfr_pkg;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 64;

   localparam logic [CsrIdxW-1:0] CSR_BASE_FORCE    = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_MIN_CONTACT   = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_MAX_FORCE     = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_SLIP_THRESH   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_DEADBANDS     = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_GAINS         = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_SIGN_FLIPS    = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_CONTACT_LEVEL = 3'd7;

   localparam logic [15:0] RST_BASE_FORCE    = 16'd256;
   localparam logic [15:0] RST_MIN_CONTACT   = 16'd128;
   localparam logic [15:0] RST_MAX_FORCE     = 16'd7680;
   localparam logic [31:0] RST_SLIP_THRESH   = 32'd13435380;
   localparam logic [31:0] RST_DEADBANDS     = 32'd8061128;
   localparam logic [63:0] RST_GAINS         = 64'd14366218931931185;
   localparam logic [5:0]  RST_SIGN_FLIPS    = 6'd0;
   localparam logic [2:0]  RST_CONTACT_LEVEL = 3'd1;

   localparam logic [19:0] US_PER_S = 20'd1000000;

   localparam int NumW  = 52;  // rate numerator / quotient
   localparam int DenW  = 20;  // step_us
   localparam int RadW  = 32;  // radicand
   localparam int RootW = 16;
   localparam int AccW  = 54;

   localparam logic [2:0] SLIP_NONE     = 3'd0;
   localparam logic [2:0] SLIP_PARTIAL  = 3'd1;
   localparam logic [2:0] SLIP_STABLE   = 3'd2;
   localparam logic [2:0] SLIP_TRANS    = 3'd3;
   localparam logic [2:0] SLIP_ROT      = 3'd4;
   localparam logic [2:0] SLIP_COMBINED = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_SQX, ST_SQY, ST_SQACC, ST_SQRTS, ST_SQRTW, ST_EVAL,
      ST_KT, ST_KR, ST_DT, ST_DTM, ST_DIV1S, ST_DIV1W, ST_DR, ST_DRM,
      ST_DIV2S, ST_DIV2W, ST_FIN, ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } unit_ctl_type;

endpackage

// File: sv/gsfr_intf.sv
// Request and response channel interfaces of the grasp slip force regulator.
// Depends on nothing; valid/ready handshake with flat payload fields.
interface gsfr_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         contact_a;
   logic signed [15:0] force_a;
   logic signed [15:0] shear_x_a;
   logic signed [15:0] shear_y_a;
   logic signed [15:0] shear_rot_a;
   logic [2:0]         contact_b;
   logic signed [15:0] force_b;
   logic signed [15:0] shear_x_b;
   logic signed [15:0] shear_y_b;
   logic signed [15:0] shear_rot_b;
   logic [19:0]        step_us;

   modport source(output valid, contact_a, force_a, shear_x_a, shear_y_a, shear_rot_a,
                  contact_b, force_b, shear_x_b, shear_y_b, shear_rot_b, step_us,
                  input ready);
   modport sink(input valid, contact_a, force_a, shear_x_a, shear_y_a, shear_rot_a,
                contact_b, force_b, shear_x_b, shear_y_b, shear_rot_b, step_us,
                output ready);
endinterface

interface gsfr_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         grip_class;
   logic               target_ok;
   logic [15:0]        target_force;
   logic signed [15:0] min_force;
   logic signed [15:0] avg_force;
   logic [15:0]        shear_trans;
   logic [15:0]        shear_rotation;

   modport source(output valid, grip_class, target_ok, target_force, min_force,
                  avg_force, shear_trans, shear_rotation, input ready);
   modport sink(input valid, grip_class, target_ok, target_force, min_force,
                avg_force, shear_trans, shear_rotation, output ready);
endinterface

// File: sv/gsfr_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on gsfr_pkg.
module gsfr_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [gsfr_pkg::RadW-1:0]       radicand,
   output logic                            busy,
   output logic [gsfr_pkg::RootW-1:0]      root
);
   localparam int RemW = gsfr_pkg::RootW + 2;
   localparam int CntW = $clog2(gsfr_pkg::RootW);

   logic [gsfr_pkg::RadW-1:0]  rad_ff, rad_in;
   logic [RemW-1:0]            rem_ff, rem_in;
   logic [gsfr_pkg::RootW-1:0] root_ff, root_in;
   logic [CntW-1:0]            cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic [RemW+1:0]            shifted;
   logic [RemW+1:0]            trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff, rad_ff[gsfr_pkg::RadW-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CntW'(gsfr_pkg::RootW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[gsfr_pkg::RadW-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = RemW'(shifted - trial);
            root_in = {root_ff[gsfr_pkg::RootW-2:0], 1'b1};
         end else begin
            rem_in  = RemW'(shifted);
            root_in = {root_ff[gsfr_pkg::RootW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule

// File: sv/gsfr_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on gsfr_pkg.
module gsfr_div (
   input  logic                       clock,
   input  logic                       reset,
   input  gsfr_pkg::unit_ctl_type     ctl_in,
   output gsfr_pkg::unit_ctl_type     ctl_out,
   input  logic [gsfr_pkg::NumW-1:0]  numer,
   input  logic [gsfr_pkg::DenW-1:0]  denom,
   output logic [gsfr_pkg::NumW-1:0]  quot
);
   localparam int CntW = $clog2(gsfr_pkg::NumW);

   logic [gsfr_pkg::NumW-1:0] quo_ff, quo_in;
   logic [gsfr_pkg::DenW-1:0] rem_ff, rem_in;
   logic [gsfr_pkg::DenW-1:0] den_ff, den_in;
   logic [CntW-1:0]           cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic [gsfr_pkg::DenW:0]   shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff, quo_ff[gsfr_pkg::NumW-1]};
      if (ctl_in.start) begin
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CntW'(gsfr_pkg::NumW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = gsfr_pkg::DenW'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[gsfr_pkg::NumW-2:0], 1'b1};
         end else begin
            rem_in = shifted[gsfr_pkg::DenW-1:0];
            quo_in = {quo_ff[gsfr_pkg::NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign ctl_out.start = 1'b0;
   assign ctl_out.busy  = busy_ff;
   assign quot          = quo_ff;
endmodule

// File: sv/grasp_slip_force_regulator.sv
// Top level of the grasp slip force regulator: sequencer, shared multiplier, registers.
// Depends on gsfr_pkg, gsfr_intf, gsfr_isqrt and gsfr_div.
//
// Usage: one reading pair is taken as a beat on req_bus (valid/ready) and one
// result beat is given on rsp_bus. The user writes registers through csr_we,
// csr_idx and csr_wdata only while the block is idle; the block does not enforce it.
// One item at a time: req_bus.ready is high only when the block is idle.
// Work per item after it is accepted:
//   no contact          none; the result is given directly
//   partial contact     16-step square root
//   full contact        the square root, the gain terms and, if enabled, the rate
//                       terms; each rate term runs a 52-step serial division, the
//                       square root takes 16 steps and a shared 32x20 multiplier
//                       is used once per cycle.
// A new item is taken only after the result of the last one has been taken.
// A result stays on rsp_bus until taken; a stalled receiver holds the block.
// Reset (synchronous, active high) loads the register defaults, clears the
// shear history and empties the block.
module grasp_slip_force_regulator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [gsfr_pkg::CsrIdxW-1:0]    csr_idx,
   input  logic [gsfr_pkg::CsrDataW-1:0]   csr_wdata,
   gsfr_req_if.sink                        req_bus,
   gsfr_rsp_if.source                      rsp_bus
);
   // registers
   logic [15:0] base_ff, minc_ff, maxf_ff;
   logic [31:0] thr_ff, db_ff;
   logic [63:0] gains_ff;
   logic [5:0]  flips_ff;
   logic [2:0]  lvl_ff;

   // history
   logic [15:0] prev_t_ff, prev_t_in, prev_r_ff, prev_r_in;
   logic        have_ff, have_in;

   gsfr_pkg::seq_state_type st_ff, st_in;

   // latched item
   logic [2:0]         ca_code_ff, cb_code_ff;
   logic signed [15:0] fa_ff, fb_ff, xa_ff, ya_ff, ra_ff, xb_ff, yb_ff, rb_ff;
   logic [19:0]        step_ff;

   // working registers
   logic [16:0]        absx_ff, absx_in, absy_ff, absy_in;
   logic               full_ff, full_in;
   logic               rate_en_ff, rate_en_in;
   logic [15:0]        et_ff, et_in, er_ff, er_in, dtr_ff, dtr_in, drr_ff, drr_in;
   logic [33:0]        n_ff, n_in;
   logic [gsfr_pkg::NumW-1:0] prod_ff;
   logic [gsfr_pkg::AccW-1:0] acc_ff, acc_in;

   // result registers
   logic [2:0]         o_state_ff, o_state_in;
   logic               o_valid_ff, o_valid_in;
   logic [15:0]        o_target_ff, o_target_in;
   logic signed [15:0] o_min_ff, o_min_in, o_avg_ff, o_avg_in;
   logic [15:0]        o_trans_ff, o_trans_in, o_rot_ff, o_rot_in;

   // shared multiplier
   logic [31:0] mul_a;
   logic [19:0] mul_b;

   // units
   logic                        sq_start, sq_busy;
   logic [gsfr_pkg::RootW-1:0]  sq_root;
   gsfr_pkg::unit_ctl_type      div_ctl, div_stat;
   logic [gsfr_pkg::NumW-1:0]   div_quot;

   // load-stage combinational values
   logic               ca, cb;
   logic signed [16:0] sxa, sxb, sya, syb, sta, stb, fsum;
   logic signed [17:0] sx, sy, stt;
   logic [17:0]        ax, ay, at;
   logic [15:0]        dbt, dbr;
   logic               ts, rs;
   logic [41:0]        inc;
   logic [16:0]        f17;
   logic [15:0]        upper;

   function automatic logic signed [16:0] flip17(input logic signed [15:0] v,
                                                 input logic neg);
      logic signed [16:0] e;
      e = {v[15], v};
      return neg ? -e : e;
   endfunction

   gsfr_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (n_ff[33:2]),
      .busy     (sq_busy),
      .root     (sq_root)
   );

   gsfr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (div_ctl),
      .ctl_out (div_stat),
      .numer   (prod_ff),
      .denom   (step_ff),
      .quot    (div_quot)
   );

   assign req_bus.ready = (st_ff == gsfr_pkg::ST_IDLE);
   assign rsp_bus.valid = (st_ff == gsfr_pkg::ST_DONE);
   assign rsp_bus.grip_class      = o_state_ff;
   assign rsp_bus.target_ok       = o_valid_ff;
   assign rsp_bus.target_force    = o_target_ff;
   assign rsp_bus.min_force       = o_min_ff;
   assign rsp_bus.avg_force       = o_avg_ff;
   assign rsp_bus.shear_trans     = o_trans_ff;
   assign rsp_bus.shear_rotation  = o_rot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= gsfr_pkg::RST_BASE_FORCE;
         minc_ff  <= gsfr_pkg::RST_MIN_CONTACT;
         maxf_ff  <= gsfr_pkg::RST_MAX_FORCE;
         thr_ff   <= gsfr_pkg::RST_SLIP_THRESH;
         db_ff    <= gsfr_pkg::RST_DEADBANDS;
         gains_ff <= gsfr_pkg::RST_GAINS;
         flips_ff <= gsfr_pkg::RST_SIGN_FLIPS;
         lvl_ff   <= gsfr_pkg::RST_CONTACT_LEVEL;
      end else if (csr_we) begin
         case (csr_idx)
            gsfr_pkg::CSR_BASE_FORCE:    base_ff  <= csr_wdata[15:0];
            gsfr_pkg::CSR_MIN_CONTACT:   minc_ff  <= csr_wdata[15:0];
            gsfr_pkg::CSR_MAX_FORCE:     maxf_ff  <= csr_wdata[15:0];
            gsfr_pkg::CSR_SLIP_THRESH:   thr_ff   <= csr_wdata[31:0];
            gsfr_pkg::CSR_DEADBANDS:     db_ff    <= csr_wdata[31:0];
            gsfr_pkg::CSR_GAINS:         gains_ff <= csr_wdata;
            gsfr_pkg::CSR_SIGN_FLIPS:    flips_ff <= csr_wdata[5:0];
            gsfr_pkg::CSR_CONTACT_LEVEL: lvl_ff   <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         ca_code_ff <= req_bus.contact_a;
         cb_code_ff <= req_bus.contact_b;
         fa_ff      <= req_bus.force_a;
         fb_ff      <= req_bus.force_b;
         xa_ff      <= req_bus.shear_x_a;
         ya_ff      <= req_bus.shear_y_a;
         ra_ff      <= req_bus.shear_rot_a;
         xb_ff      <= req_bus.shear_x_b;
         yb_ff      <= req_bus.shear_y_b;
         rb_ff      <= req_bus.shear_rot_b;
         step_ff    <= req_bus.step_us;
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (st_ff)
         gsfr_pkg::ST_SQX: begin
            mul_a = {15'd0, absx_ff};
            mul_b = {3'd0, absx_ff};
         end
         gsfr_pkg::ST_SQY: begin
            mul_a = {15'd0, absy_ff};
            mul_b = {3'd0, absy_ff};
         end
         gsfr_pkg::ST_KT: begin
            mul_a = {16'd0, gains_ff[15:0]};
            mul_b = {4'd0, et_ff};
         end
         gsfr_pkg::ST_KR: begin
            mul_a = {16'd0, gains_ff[47:32]};
            mul_b = {4'd0, er_ff};
         end
         gsfr_pkg::ST_DT: begin
            mul_a = {16'd0, gains_ff[31:16]};
            mul_b = {4'd0, dtr_ff};
         end
         gsfr_pkg::ST_DR: begin
            mul_a = {16'd0, gains_ff[63:48]};
            mul_b = {4'd0, drr_ff};
         end
         gsfr_pkg::ST_DTM, gsfr_pkg::ST_DRM: begin
            mul_a = prod_ff[31:0];
            mul_b = gsfr_pkg::US_PER_S;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // load-stage arithmetic
   always_comb begin
      ca   = ca_code_ff >= lvl_ff;
      cb   = cb_code_ff >= lvl_ff;
      sxa  = flip17(xa_ff, flips_ff[0]);
      sya  = flip17(ya_ff, flips_ff[1]);
      sta  = flip17(ra_ff, flips_ff[2]);
      sxb  = flip17(xb_ff, flips_ff[3]);
      syb  = flip17(yb_ff, flips_ff[4]);
      stb  = flip17(rb_ff, flips_ff[5]);
      sx   = {sxa[16], sxa} + {sxb[16], sxb};
      sy   = {sya[16], sya} + {syb[16], syb};
      stt  = {sta[16], sta} + {stb[16], stb};
      ax   = sx[17] ? 18'(-sx) : 18'(sx);
      ay   = sy[17] ? 18'(-sy) : 18'(sy);
      at   = stt[17] ? 18'(-stt) : 18'(stt);
      fsum = {fa_ff[15], fa_ff} + {fb_ff[15], fb_ff};
      dbt  = db_ff[15:0];
      dbr  = db_ff[31:16];
      ts   = sq_root > thr_ff[15:0];
      rs   = o_rot_ff > thr_ff[31:16];
      inc  = acc_ff[gsfr_pkg::AccW-1:12];
      f17  = {1'b0, base_ff} + {1'b0, inc[15:0]};
      upper = (maxf_ff < minc_ff) ? minc_ff : maxf_ff;
   end

   always_comb begin
      st_in       = st_ff;
      prev_t_in   = prev_t_ff;
      prev_r_in   = prev_r_ff;
      have_in     = have_ff;
      absx_in     = absx_ff;
      absy_in     = absy_ff;
      full_in     = full_ff;
      rate_en_in  = rate_en_ff;
      et_in       = et_ff;
      er_in       = er_ff;
      dtr_in      = dtr_ff;
      drr_in      = drr_ff;
      n_in        = n_ff;
      acc_in      = acc_ff;
      o_state_in  = o_state_ff;
      o_valid_in  = o_valid_ff;
      o_target_in = o_target_ff;
      o_min_in    = o_min_ff;
      o_avg_in    = o_avg_ff;
      o_trans_in  = o_trans_ff;
      o_rot_in    = o_rot_ff;
      sq_start    = 1'b0;
      div_ctl     = '0;

      case (st_ff)
         gsfr_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               st_in = gsfr_pkg::ST_LOAD;
            end
         end
         gsfr_pkg::ST_LOAD: begin
            o_valid_in  = 1'b0;
            o_target_in = '0;
            o_min_in    = '0;
            o_avg_in    = '0;
            o_trans_in  = '0;
            o_rot_in    = '0;
            absx_in     = ax[16:0];
            absy_in     = ay[16:0];
            if (ca && cb) begin
               o_min_in = (fa_ff < fb_ff) ? fa_ff : fb_ff;
               o_avg_in = fsum[16:1];
            end else if (ca) begin
               o_avg_in = {fa_ff[15], fa_ff[15:1]};
            end else if (cb) begin
               o_avg_in = {fb_ff[15], fb_ff[15:1]};
            end
            full_in = ca && cb && (((fa_ff < fb_ff) ? fa_ff : fb_ff) >= $signed({1'b0, minc_ff}));
            if (!ca && !cb) begin
               o_state_in = gsfr_pkg::SLIP_NONE;
               have_in    = 1'b0;
               prev_t_in  = '0;
               prev_r_in  = '0;
               st_in      = gsfr_pkg::ST_DONE;
            end else begin
               o_rot_in = at[16:1];
               st_in    = gsfr_pkg::ST_SQX;
            end
         end
         gsfr_pkg::ST_SQX: st_in = gsfr_pkg::ST_SQY;
         gsfr_pkg::ST_SQY: begin
            n_in  = prod_ff[33:0];
            st_in = gsfr_pkg::ST_SQACC;
         end
         gsfr_pkg::ST_SQACC: begin
            n_in  = n_ff + prod_ff[33:0];
            st_in = gsfr_pkg::ST_SQRTS;
         end
         gsfr_pkg::ST_SQRTS: begin
            sq_start = 1'b1;
            st_in    = gsfr_pkg::ST_SQRTW;
         end
         gsfr_pkg::ST_SQRTW: begin
            if (!sq_busy) begin
               st_in = gsfr_pkg::ST_EVAL;
            end
         end
         gsfr_pkg::ST_EVAL: begin
            o_trans_in = sq_root;
            if (!full_ff) begin
               o_state_in = gsfr_pkg::SLIP_PARTIAL;
               have_in    = 1'b0;
               prev_t_in  = '0;
               prev_r_in  = '0;
               st_in      = gsfr_pkg::ST_DONE;
            end else begin
               o_state_in = (ts && rs) ? gsfr_pkg::SLIP_COMBINED :
                            ts ? gsfr_pkg::SLIP_TRANS :
                            rs ? gsfr_pkg::SLIP_ROT : gsfr_pkg::SLIP_STABLE;
               et_in      = (sq_root > dbt) ? sq_root - dbt : '0;
               er_in      = (o_rot_ff > dbr) ? o_rot_ff - dbr : '0;
               dtr_in     = (sq_root > prev_t_ff) ? sq_root - prev_t_ff : '0;
               drr_in     = (o_rot_ff > prev_r_ff) ? o_rot_ff - prev_r_ff : '0;
               rate_en_in = have_ff && (step_ff != '0);
               st_in      = gsfr_pkg::ST_KT;
            end
         end
         gsfr_pkg::ST_KT: st_in = gsfr_pkg::ST_KR;
         gsfr_pkg::ST_KR: begin
            acc_in = {22'd0, prod_ff[31:0]};
            st_in  = gsfr_pkg::ST_DT;
         end
         gsfr_pkg::ST_DT: begin
            acc_in = acc_ff + {22'd0, prod_ff[31:0]};
            st_in  = gsfr_pkg::ST_DTM;
         end
         gsfr_pkg::ST_DTM: st_in = gsfr_pkg::ST_DIV1S;
         gsfr_pkg::ST_DIV1S: begin
            div_ctl.start = rate_en_ff;
            st_in = rate_en_ff ? gsfr_pkg::ST_DIV1W : gsfr_pkg::ST_DR;
         end
         gsfr_pkg::ST_DIV1W: begin
            if (!div_stat.busy) begin
               acc_in = acc_ff + {2'd0, div_quot};
               st_in  = gsfr_pkg::ST_DR;
            end
         end
         gsfr_pkg::ST_DR:  st_in = gsfr_pkg::ST_DRM;
         gsfr_pkg::ST_DRM: st_in = gsfr_pkg::ST_DIV2S;
         gsfr_pkg::ST_DIV2S: begin
            div_ctl.start = rate_en_ff;
            st_in = rate_en_ff ? gsfr_pkg::ST_DIV2W : gsfr_pkg::ST_FIN;
         end
         gsfr_pkg::ST_DIV2W: begin
            if (!div_stat.busy) begin
               acc_in = acc_ff + {2'd0, div_quot};
               st_in  = gsfr_pkg::ST_FIN;
            end
         end
         gsfr_pkg::ST_FIN: begin
            if (inc[41:16] != '0) begin
               o_target_in = upper;
            end else if (f17 < {1'b0, minc_ff}) begin
               o_target_in = minc_ff;
            end else if (f17 > {1'b0, upper}) begin
               o_target_in = upper;
            end else begin
               o_target_in = f17[15:0];
            end
            o_valid_in = 1'b1;
            prev_t_in  = o_trans_ff;
            prev_r_in  = o_rot_ff;
            have_in    = 1'b1;
            st_in      = gsfr_pkg::ST_DONE;
         end
         gsfr_pkg::ST_DONE: begin
            if (rsp_bus.ready) begin
               st_in = gsfr_pkg::ST_IDLE;
            end
         end
         default: st_in = gsfr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= gsfr_pkg::ST_IDLE;
         prev_t_ff <= '0;
         prev_r_ff <= '0;
         have_ff   <= 1'b0;
      end else begin
         st_ff     <= st_in;
         prev_t_ff <= prev_t_in;
         prev_r_ff <= prev_r_in;
         have_ff   <= have_in;
      end
      absx_ff     <= absx_in;
      absy_ff     <= absy_in;
      full_ff     <= full_in;
      rate_en_ff  <= rate_en_in;
      et_ff       <= et_in;
      er_ff       <= er_in;
      dtr_ff      <= dtr_in;
      drr_ff      <= drr_in;
      n_ff        <= n_in;
      acc_ff      <= acc_in;
      o_state_ff  <= o_state_in;
      o_valid_ff  <= o_valid_in;
      o_target_ff <= o_target_in;
      o_min_ff    <= o_min_in;
      o_avg_ff    <= o_avg_in;
      o_trans_ff  <= o_trans_in;
      o_rot_ff    <= o_rot_in;
   end
endmodule

// File: sim/tb.sv
// Testbench for grasp_slip_force_regulator: drives reading pairs, predicts results, checks them.
// Depends on gsfr_pkg, gsfr_intf and the RTL of the block; needs no files at run time.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]         contact_a;
      logic signed [15:0] force_a;
      logic signed [15:0] shear_x_a;
      logic signed [15:0] shear_y_a;
      logic signed [15:0] shear_rot_a;
      logic [2:0]         contact_b;
      logic signed [15:0] force_b;
      logic signed [15:0] shear_x_b;
      logic signed [15:0] shear_y_b;
      logic signed [15:0] shear_rot_b;
      logic [19:0]        step_us;
   } reading_type;

   typedef struct packed {
      logic [2:0]         grip_class;
      logic               target_ok;
      logic [15:0]        target_force;
      logic signed [15:0] min_force;
      logic signed [15:0] avg_force;
      logic [15:0]        shear_trans;
      logic [15:0]        shear_rotation;
   } grip_out_type;

   localparam int CycleLimit = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [gsfr_pkg::CsrIdxW-1:0] csr_idx = '0;
   logic [gsfr_pkg::CsrDataW-1:0] csr_wdata = '0;

   gsfr_req_if req_bus ();
   gsfr_rsp_if rsp_bus ();

   grasp_slip_force_regulator u_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_idx  (csr_idx),
      .csr_wdata(csr_wdata),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // register copies and shear history of the predictor
   logic [15:0] m_base, m_min, m_max;
   logic [31:0] m_thresh, m_dband;
   logic [63:0] m_gains;
   logic [5:0]  m_flips;
   logic [2:0]  m_level;
   logic [15:0] hist_trans, hist_rot;
   logic        hist_ok;

   reading_type  reading_q[$];
   grip_out_type grip_q[$];
   reading_type  cur_reading;
   int           n_queued, n_checked, n_errors, n_cycles, send_gap, stall_cnt;
   int           state_seen[6];
   bit           idle_on = 1'b1;

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic int flipped(input logic signed [15:0] v, input int b);
      return m_flips[b] ? -int'(v) : int'(v);
   endfunction

   function automatic longint unsigned shear_rate(input longint unsigned g,
                                                  input logic [15:0] now,
                                                  input logic [15:0] was,
                                                  input longint unsigned step);
      if (!hist_ok || step == 0 || now <= was) return 0;
      return (g * longint'(now - was) * 64'd1000000) / step;
   endfunction

   function automatic grip_out_type predict_grip(input reading_type r);
      grip_out_type o;
      bit ca, cb, ts, rs;
      int fa, fb, minf, avgf, sx, sy, st;
      longint unsigned trans, rot, et, er, sum, tgt, upper;
      o = '0;
      ca = r.contact_a >= m_level;
      cb = r.contact_b >= m_level;
      fa = int'(r.force_a);
      fb = int'(r.force_b);
      minf = 0;
      avgf = 0;
      trans = 0;
      rot = 0;
      if (ca && cb) begin
         minf = fa < fb ? fa : fb;
         avgf = (fa + fb) >>> 1;
      end else if (ca) begin
         avgf = fa >>> 1;
      end else if (cb) begin
         avgf = fb >>> 1;
      end
      if (!ca && !cb) begin
         o.grip_class = gsfr_pkg::SLIP_NONE;
         hist_ok = 0; hist_trans = 0; hist_rot = 0;
      end else begin
         sx = flipped(r.shear_x_a, 0) + flipped(r.shear_x_b, 3);
         sy = flipped(r.shear_y_a, 1) + flipped(r.shear_y_b, 4);
         st = flipped(r.shear_rot_a, 2) + flipped(r.shear_rot_b, 5);
         trans = int_sqrt((longint'(sx) * sx + longint'(sy) * sy) >> 2);
         rot = longint'((st < 0 ? -st : st) >> 1);
         if (!ca || !cb || minf < int'(m_min)) begin
            o.grip_class = gsfr_pkg::SLIP_PARTIAL;
            hist_ok = 0; hist_trans = 0; hist_rot = 0;
         end else begin
            ts = trans > m_thresh[15:0];
            rs = rot > m_thresh[31:16];
            et = trans > m_dband[15:0] ? trans - m_dband[15:0] : 0;
            er = rot > m_dband[31:16] ? rot - m_dband[31:16] : 0;
            o.grip_class = (ts && rs) ? gsfr_pkg::SLIP_COMBINED :
                           ts ? gsfr_pkg::SLIP_TRANS :
                           rs ? gsfr_pkg::SLIP_ROT : gsfr_pkg::SLIP_STABLE;
            sum = m_gains[15:0] * et + m_gains[47:32] * er
                + shear_rate(m_gains[31:16], trans[15:0], hist_trans, r.step_us)
                + shear_rate(m_gains[63:48], rot[15:0], hist_rot, r.step_us);
            hist_trans = trans[15:0];
            hist_rot = rot[15:0];
            hist_ok = 1;
            tgt = m_base + (sum >> 12);
            upper = m_max < m_min ? m_min : m_max;
            if (tgt < m_min) tgt = m_min;
            if (tgt > upper) tgt = upper;
            o.target_force = tgt[15:0];
            o.target_ok = 1'b1;
         end
      end
      o.min_force = minf[15:0];
      o.avg_force = avgf[15:0];
      o.shear_trans = trans[15:0];
      o.shear_rotation = rot[15:0];
      return o;
   endfunction

   // sender
   always @(posedge clock) begin
      logic nv;
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.contact_a   <= '0;
         req_bus.force_a     <= '0;
         req_bus.shear_x_a   <= '0;
         req_bus.shear_y_a   <= '0;
         req_bus.shear_rot_a <= '0;
         req_bus.contact_b   <= '0;
         req_bus.force_b     <= '0;
         req_bus.shear_x_b   <= '0;
         req_bus.shear_y_b   <= '0;
         req_bus.shear_rot_b <= '0;
         req_bus.step_us     <= '0;
         send_gap = 0;
      end else begin
         nv = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            grip_q.push_back(predict_grip(cur_reading));
            nv = 1'b0;
         end
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (reading_q.size() > 0) begin
               if (idle_on && $urandom_range(4, 0) == 0) begin
                  send_gap = $urandom_range(3, 1) - 1;
               end else begin
                  cur_reading = reading_q.pop_front();
                  req_bus.contact_a   <= cur_reading.contact_a;
                  req_bus.force_a     <= cur_reading.force_a;
                  req_bus.shear_x_a   <= cur_reading.shear_x_a;
                  req_bus.shear_y_a   <= cur_reading.shear_y_a;
                  req_bus.shear_rot_a <= cur_reading.shear_rot_a;
                  req_bus.contact_b   <= cur_reading.contact_b;
                  req_bus.force_b     <= cur_reading.force_b;
                  req_bus.shear_x_b   <= cur_reading.shear_x_b;
                  req_bus.shear_y_b   <= cur_reading.shear_y_b;
                  req_bus.shear_rot_b <= cur_reading.shear_rot_b;
                  req_bus.step_us     <= cur_reading.step_us;
                  nv = 1'b1;
               end
            end
         end
         req_bus.valid <= nv;
      end
   end

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         n_errors++;
         if (n_errors <= 10)
            $display("mismatch beat %0d %s: expected %0d, got %0d", n_checked, name, want, got);
      end
   endtask

   // receiver and checker
   always @(posedge clock) begin
      grip_out_type w;
      logic nr;
      n_cycles++;
      if (n_cycles > CycleLimit) begin
         $display("timeout after %0d cycles", n_cycles);
         $display("tb: errors");
         $finish;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_cnt = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (grip_q.size() == 0) begin
               n_errors++;
               if (n_errors <= 10) $display("result beat with nothing outstanding");
            end else begin
               w = grip_q.pop_front();
               check_field("grip_class", longint'(w.grip_class),
                           longint'(rsp_bus.grip_class));
               check_field("target_ok", longint'(w.target_ok), longint'(rsp_bus.target_ok));
               check_field("target_force", longint'(w.target_force),
                           longint'(rsp_bus.target_force));
               check_field("min_force", longint'(w.min_force), longint'(rsp_bus.min_force));
               check_field("avg_force", longint'(w.avg_force), longint'(rsp_bus.avg_force));
               check_field("shear_trans", longint'(w.shear_trans),
                           longint'(rsp_bus.shear_trans));
               check_field("shear_rotation", longint'(w.shear_rotation),
                           longint'(rsp_bus.shear_rotation));
               if (w.grip_class < 6) state_seen[w.grip_class]++;
               n_checked++;
            end
         end
         if (stall_cnt > 0) begin
            stall_cnt--;
            nr = 1'b0;
         end else if (idle_on && $urandom_range(3, 0) == 0) begin
            stall_cnt = $urandom_range(3, 1) - 1;
            nr = 1'b0;
         end else begin
            nr = 1'b1;
         end
         rsp_bus.ready <= nr;
      end
   end

   task automatic csr_wr(input logic [gsfr_pkg::CsrIdxW-1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= val;
      case (idx)
         gsfr_pkg::CSR_BASE_FORCE:    m_base = val[15:0];
         gsfr_pkg::CSR_MIN_CONTACT:   m_min = val[15:0];
         gsfr_pkg::CSR_MAX_FORCE:     m_max = val[15:0];
         gsfr_pkg::CSR_SLIP_THRESH:   m_thresh = val[31:0];
         gsfr_pkg::CSR_DEADBANDS:     m_dband = val[31:0];
         gsfr_pkg::CSR_GAINS:         m_gains = val;
         gsfr_pkg::CSR_SIGN_FLIPS:    m_flips = val[5:0];
         gsfr_pkg::CSR_CONTACT_LEVEL: m_level = val[2:0];
         default: ;
      endcase
   endtask

   task automatic load_regs(input logic [15:0] b, input logic [15:0] mn, input logic [15:0] mx,
                            input logic [31:0] th, input logic [31:0] db,
                            input logic [63:0] g, input logic [5:0] fl, input logic [2:0] lv);
      csr_wr(gsfr_pkg::CSR_BASE_FORCE, 64'(b));
      csr_wr(gsfr_pkg::CSR_MIN_CONTACT, 64'(mn));
      csr_wr(gsfr_pkg::CSR_MAX_FORCE, 64'(mx));
      csr_wr(gsfr_pkg::CSR_SLIP_THRESH, 64'(th));
      csr_wr(gsfr_pkg::CSR_DEADBANDS, 64'(db));
      csr_wr(gsfr_pkg::CSR_GAINS, g);
      csr_wr(gsfr_pkg::CSR_SIGN_FLIPS, 64'(fl));
      csr_wr(gsfr_pkg::CSR_CONTACT_LEVEL, 64'(lv));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send(input reading_type r);
      reading_q.push_back(r);
      n_queued++;
   endtask

   task automatic drain();
      wait (n_checked == n_queued);
      repeat (8) @(posedge clock);
   endtask

   function automatic reading_type mk(input int ca, input int fa, input int xa, input int ya,
                                      input int ra, input int cb, input int fb, input int xb,
                                      input int yb, input int rb, input int step);
      reading_type r;
      r.contact_a = 3'(ca); r.force_a = 16'(fa); r.shear_x_a = 16'(xa);
      r.shear_y_a = 16'(ya); r.shear_rot_a = 16'(ra); r.contact_b = 3'(cb);
      r.force_b = 16'(fb); r.shear_x_b = 16'(xb); r.shear_y_b = 16'(yb);
      r.shear_rot_b = 16'(rb); r.step_us = 20'(step);
      return r;
   endfunction

   function automatic int around(input int c, input int span);
      return c + int'($urandom_range(2 * span)) - span;
   endfunction

   // mostly gripping sequences with drifting shear, some noise and broken contact
   task automatic random_readings(input int n);
      reading_type r;
      logic [159:0] noise;
      int kind, cx, cy, ct, fmin;
      cx = 0; cy = 0; ct = 0;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(9, 0);
         if (kind < 2) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
            r = noise[$bits(reading_type)-1:0];
         end else begin
            cx = around(cx, 150); cy = around(cy, 150); ct = around(ct, 80);
            if (cx > 8000 || cx < -8000) cx = 0;
            if (cy > 8000 || cy < -8000) cy = 0;
            if (ct > 4000 || ct < -4000) ct = 0;
            fmin = m_min > 32767 ? 32767 : int'(m_min);
            r = mk($urandom_range(7, m_level), $urandom_range(32767, fmin),
                   around(cx, 300), around(cy, 300), around(ct, 100),
                   $urandom_range(7, m_level), $urandom_range(32767, fmin),
                   around(cx, 300), around(cy, 300), around(ct, 100),
                   $urandom_range(3, 0) == 0 ? $urandom_range(20'hFFFFF) :
                   $urandom_range(5000, 50));
            if (kind == 2) r.step_us = '0;
            if (kind == 3) r.contact_b = 3'($urandom_range(7));
            if (kind == 4) r.force_a = 16'($urandom);
         end
         send(r);
      end
   endtask

   initial begin
      m_base = gsfr_pkg::RST_BASE_FORCE; m_min = gsfr_pkg::RST_MIN_CONTACT;
      m_max = gsfr_pkg::RST_MAX_FORCE; m_thresh = gsfr_pkg::RST_SLIP_THRESH;
      m_dband = gsfr_pkg::RST_DEADBANDS; m_gains = gsfr_pkg::RST_GAINS;
      m_flips = gsfr_pkg::RST_SIGN_FLIPS; m_level = gsfr_pkg::RST_CONTACT_LEVEL;
      hist_ok = 0; hist_trans = 0; hist_rot = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, reset register values
      send(mk(0, 1000, 10, 10, 10, 0, 1000, 10, 10, 10, 100));      // no contact
      send(mk(3, -32768, 500, -20, 7, 0, 5, 1, 1, 1, 100));         // only A
      send(mk(0, 9, 1, 1, 1, 7, 32767, -32768, 32767, -32768, 100)); // only B
      send(mk(1, 100, 0, 0, 0, 1, 4000, 0, 0, 0, 100));             // weak grip
      send(mk(2, 2000, 50, 50, 20, 2, 2100, 50, 50, 20, 1000));     // stable
      send(mk(2, 2000, 300, 300, 20, 2, 2100, 300, 300, 20, 1000)); // rising shear
      send(mk(2, 2000, 900, 100, 20, 2, 2100, 900, 100, 20, 0));    // no step
      send(mk(2, 2000, 100, 0, 300, 2, 2100, 100, 0, 300, 1000));   // rotational
      send(mk(2, 2000, 900, 0, 400, 2, 2100, 900, 0, 400, 1));      // combined
      send(mk(2, 2000, 10, 0, 5, 2, 2100, 10, 0, 5, 20'hFFFFF));    // falling
      send(mk(7, 32767, -32768, -32768, -32768, 7, 32767, -32768, -32768, -32768, 1));
      send(mk(7, 32767, 32767, 32767, 32767, 7, 32767, 32767, 32767, 32767, 1));
      send(mk(5, 128, -1, -1, -1, 6, 127, 1, 1, 1, 2));
      send(mk(4, 129, 2000, -2000, -900, 4, 128, 2000, -2000, -900, 3));
      send(mk(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
      random_readings(70);
      drain();

      load_regs(16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 64'd0, 6'd0, 3'd0);
      send(mk(0, -32768, 3, 4, 0, 0, -32768, 3, 4, 0, 10));
      random_readings(60);
      drain();

      load_regs(16'hFFFF, 16'hFFFF, 16'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, '1, 6'h3F, 3'd7);
      random_readings(30);
      drain();

      load_regs(16'hFFFF, 16'd0, 16'hFFFF, 32'd0, 32'd0, '1, 6'h2A, 3'd0);
      random_readings(40);
      drain();

      load_regs(16'($urandom_range(4000)), 16'($urandom_range(1500)),
                16'($urandom_range(20000)),
                {16'($urandom_range(800)), 16'($urandom_range(3000))},
                {16'($urandom_range(400)), 16'($urandom_range(1500))},
                {$urandom, $urandom}, 6'($urandom_range(63)), 3'($urandom_range(4)));
      random_readings(100);
      drain();

      idle_on = 1'b0;
      load_regs(16'($urandom_range(4000)), 16'($urandom_range(1500)),
                16'($urandom_range(20000)),
                {16'($urandom_range(800)), 16'($urandom_range(3000))},
                {16'($urandom_range(400)), 16'($urandom_range(1500))},
                {$urandom, $urandom}, 6'($urandom_range(63)), 3'($urandom_range(3)));
      random_readings(100);
      drain();

      $display("covered %0d readings over 6 register settings in %0d cycles", n_checked,
               n_cycles);
      $display("slip states none/partial/stable/trans/rot/combined: %0d %0d %0d %0d %0d %0d",
               state_seen[0], state_seen[1], state_seen[2], state_seen[3], state_seen[4],
               state_seen[5]);
      if (n_errors == 0 && grip_q.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
